// ===== sv/wfcq_pkg.sv =====
// Shared types and constants of the Wiegand frame capture queue.
package wfcq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 8;
  localparam int unsigned BIT_LIMIT           = 63;
  localparam logic [31:0] TIMEOUT_RESET       = 32'd30000;
  localparam logic [15:0] MIN_SPACING_RESET   = 16'd200;
  localparam logic [15:0] SAT16               = 16'hFFFF;

  // Register indexes, taken from paddr[2].
  localparam logic REG_TIMEOUT     = 1'b0;
  localparam logic REG_MIN_SPACING = 1'b1;

  typedef enum logic [1:0] {
    FUNC_ZERO = 2'd0,
    FUNC_ONE  = 2'd1,
    FUNC_POLL = 2'd2
  } func_e;

  // One captured frame, open or queued.
  typedef struct packed {
    logic [15:0] ones;
    logic [15:0] zeros;
    logic        ovf;
    logic [31:0] last;
    logic [31:0] first;
    logic [5:0]  count;
    logic [62:0] bits;
  } frame_t;

endpackage

// ===== sv/wiegand_frame_capture_queue_unit.sv =====
// Wiegand frame capture queue: pulse capture, frame ring queue and poll interface.
//
// Channel   Direction  Handshake                 Payload
// s_*       in         s_tvalid_i / s_tready_o   tuser: func; tdata: now_us
// m_*       out        m_tvalid_o / m_tready_i   tuser: frame_valid; tdata: frame result
// apb       in         psel/penable/pwrite       timeout_us at 0x0, min_spacing_us at 0x4
//
// One request is taken per clock cycle while the result stage is free or can move
// on, and every request yields exactly one result. A result passes first through the
// result stage, with the state update and the registered read of the frame memory,
// then through the output register that drives m_tvalid_o. The two form a two-entry
// buffer, so one more request is taken while a result waits on a stalled output.
// Reset clears the open frame, the queue pointers, the fill count and the dropped
// count at once; the frame memory itself is not cleared and needs no clearing pass.
module wiegand_frame_capture_queue_unit #(
  parameter int unsigned QueueDepth = wfcq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input requests.
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  input  logic [31:0]  s_tdata_i,   // [31:0] now_us
  input  logic [1:0]   s_tuser_i,   // [1:0] func
  // Results.
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  // [62:0] frame_bits, [68:63] bit_total, [100:69] first_pulse_time,
  // [132:101] last_pulse_time, [133] overflowed, [149:134] zero_pulses,
  // [165:150] one_pulses, [181:166] dropped_total, [182] pending, [183] zero
  output logic [183:0] m_tdata_o,
  output logic         m_tuser_o,   // [0] frame_valid
  // Configuration port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned IdxW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned FillW = $clog2(QueueDepth + 1);
  localparam logic [IdxW-1:0]  LastIdx  = IdxW'(QueueDepth - 1);
  localparam logic [FillW-1:0] FullFill = FillW'(QueueDepth);

  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] i);
    next_idx = (i == LastIdx) ? '0 : i + IdxW'(1);
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes only decode paddr[2]; pready never stalls.
  // ---------------------------------------------------------------------------
  logic [31:0] timeout_q;
  logic [15:0] min_spacing_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q     <= wfcq_pkg::TIMEOUT_RESET;
      min_spacing_q <= wfcq_pkg::MIN_SPACING_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == wfcq_pkg::REG_TIMEOUT) begin
        timeout_q <= pwdata;
      end else begin
        min_spacing_q <= pwdata[15:0];
      end
    end
  end

  assign prdata = (paddr[2] == wfcq_pkg::REG_MIN_SPACING) ? {16'b0, min_spacing_q} : timeout_q;

  // ---------------------------------------------------------------------------
  // Handshake and pipeline control.
  // ---------------------------------------------------------------------------
  logic r_valid_q, out_valid_q;
  logic out_load, accept;

  assign out_load   = !out_valid_q || m_tready_i;
  assign s_tready_o = !r_valid_q || out_load;
  assign accept     = s_tvalid_i && s_tready_o;

  // ---------------------------------------------------------------------------
  // Step logic: timeout close, pulse capture, queue update and pop.
  // ---------------------------------------------------------------------------
  wfcq_pkg::frame_t open_q, open_d, open_c;
  logic [IdxW-1:0]  head_q, head_d, tail_q, tail_d, head_a;
  logic [FillW-1:0] fill_q, fill_d, fill_a, fill_b;
  logic [15:0]      dropped_q, dropped_d, dropped_a;

  logic [31:0] gap;
  logic        is_pulse, is_poll, timed_out, close_w, full, too_close, take, pop, bypass;
  logic        pending;

  assign is_pulse  = (s_tuser_i == wfcq_pkg::FUNC_ZERO) || (s_tuser_i == wfcq_pkg::FUNC_ONE);
  assign is_poll   = (s_tuser_i == wfcq_pkg::FUNC_POLL);
  assign gap       = s_tdata_i - open_q.last;
  assign timed_out = (open_q.count != '0) && (gap >= timeout_q);
  assign close_w   = accept && (is_pulse || is_poll) && timed_out;
  assign full      = (fill_q >= FullFill);

  always_comb begin
    // Closing a full queue first drops its oldest frame.
    head_a    = head_q;
    fill_a    = fill_q;
    dropped_a = dropped_q;
    if (close_w && full) begin
      head_a = next_idx(head_q);
      fill_a = fill_q - FillW'(1);
      if (dropped_q != wfcq_pkg::SAT16) begin
        dropped_a = dropped_q + 16'd1;
      end
    end
    fill_b = close_w ? fill_a + FillW'(1) : fill_a;
    tail_d = close_w ? next_idx(tail_q) : tail_q;

    pop    = accept && is_poll && (fill_b != '0);
    // The popped slot is the one written in this very step.
    bypass = close_w && (head_a == tail_q);
    head_d    = pop ? next_idx(head_a) : head_a;
    fill_d    = pop ? fill_b - FillW'(1) : fill_b;
    dropped_d = pop ? 16'd0 : dropped_a;
  end

  always_comb begin
    open_c    = close_w ? '0 : open_q;
    open_d    = open_c;
    // The spacing check only applies within a frame that is still open.
    too_close = (open_c.count != '0) && (gap < {16'b0, min_spacing_q});
    take      = accept && is_pulse && !too_close;
    if (take) begin
      if (open_c.count == '0) begin
        open_d.first = s_tdata_i;
      end
      if (s_tuser_i[0]) begin
        if (open_c.ones != wfcq_pkg::SAT16) begin
          open_d.ones = open_c.ones + 16'd1;
        end
      end else begin
        if (open_c.zeros != wfcq_pkg::SAT16) begin
          open_d.zeros = open_c.zeros + 16'd1;
        end
      end
      if (open_c.count < 6'(wfcq_pkg::BIT_LIMIT)) begin
        open_d.bits  = {open_c.bits[61:0], s_tuser_i[0]};
        open_d.count = open_c.count + 6'd1;
      end else begin
        open_d.ovf = 1'b1;
      end
      open_d.last = s_tdata_i;
    end
  end

  assign pending = (open_d.count != '0) || (fill_d != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q    <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      fill_q    <= '0;
      dropped_q <= '0;
    end else if (accept) begin
      open_q    <= open_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      fill_q    <= fill_d;
      dropped_q <= dropped_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame memory: one write port at the tail, one registered read at the head.
  // ---------------------------------------------------------------------------
  wfcq_pkg::frame_t mem_q [QueueDepth];
  wfcq_pkg::frame_t rd_q, byp_frame_q;
  logic             r_fv_q, r_byp_q, r_pend_q;
  logic [15:0]      r_drop_q;

  always_ff @(posedge clk_i) begin
    if (close_w) begin
      mem_q[tail_q] <= open_q;
    end
    if (pop) begin
      rd_q <= mem_q[head_a];
    end
  end

  // Result stage payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      r_fv_q      <= pop;
      r_byp_q     <= bypass;
      byp_frame_q <= open_q;
      r_drop_q    <= dropped_a;
      r_pend_q    <= pending;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else if (accept) begin
      r_valid_q <= 1'b1;
    end else if (out_load) begin
      r_valid_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register. Without a popped frame all frame fields read as zero.
  // ---------------------------------------------------------------------------
  wfcq_pkg::frame_t frame_sel;
  logic [15:0]      drop_sel;
  logic [183:0]     out_data_q;
  logic             out_user_q;

  assign frame_sel = !r_fv_q ? '0 : (r_byp_q ? byp_frame_q : rd_q);
  assign drop_sel  = r_fv_q ? r_drop_q : 16'd0;

  always_ff @(posedge clk_i) begin
    if (out_load && r_valid_q) begin
      out_data_q <= {1'b0, r_pend_q, drop_sel, frame_sel.ones, frame_sel.zeros,
                     frame_sel.ovf, frame_sel.last, frame_sel.first,
                     frame_sel.count, frame_sel.bits};
      out_user_q <= r_fv_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= r_valid_q;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = out_user_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FullFill)
    else $error("queue fill count exceeds the queue depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_poll && fill_q == '0 && !close_w) |=> !r_fv_q)
    else $error("frame popped from an empty queue");

  a_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (r_pend_q == ((open_q.count != '0) || (fill_q != '0))))
    else $error("pending flag disagrees with the stored state");

  a_stage_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r_valid_q && !out_load) |=> r_valid_q)
    else $error("result stage lost a result while the output stalled");

endmodule

// ===== tb/wiegand_frame_capture_queue_unit_tb.sv =====
// Self-checking testbench for the Wiegand frame capture queue unit.
`timescale 1ns / 100ps

module wiegand_frame_capture_queue_unit_tb;

  // Function code that the block must ignore apart from reporting pending.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam int RING_DEPTH       = wfcq_pkg::QUEUE_DEPTH_DEFAULT;
  localparam int MAX_SHOWN        = 10;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int LONG_HOLD_CYCLES = 400;
  // Pulses in one frame, enough to run past the 63-bit store.
  localparam int BIT_OVERRUN      = 80;

  // One input request: an edge on a data line or a poll, with its timestamp.
  typedef struct {
    logic [1:0]  func;
    logic [31:0] now;
  } wiegand_event_t;

  // What one request should produce on the result channel.
  typedef struct {
    logic             valid;
    wfcq_pkg::frame_t frame;
    logic [15:0]      dropped;
    logic             pending;
  } poll_result_t;

  logic         clk_i      = 1'b0;
  logic         rst_ni     = 1'b0;
  logic         s_tvalid_i = 1'b0;
  logic         s_tready_o;
  logic [31:0]  s_tdata_i  = '0;
  logic [1:0]   s_tuser_i  = '0;
  logic         m_tvalid_o;
  logic         m_tready_i = 1'b0;
  logic [183:0] m_tdata_o;
  logic         m_tuser_o;
  logic         psel       = 1'b0;
  logic         penable    = 1'b0;
  logic         pwrite     = 1'b0;
  logic [2:0]   paddr      = '0;
  logic [31:0]  pwdata     = '0;
  logic [31:0]  prdata;
  logic         pready;

  wiegand_frame_capture_queue_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state. It mirrors the open frame, the ring of closed frames and
  // the dropped-frame tally, together with the two configuration registers.
  // ---------------------------------------------------------------------------
  logic [31:0]      timeout_cfg = wfcq_pkg::TIMEOUT_RESET;
  logic [15:0]      spacing_cfg = wfcq_pkg::MIN_SPACING_RESET;
  wfcq_pkg::frame_t open_frame  = '0;
  wfcq_pkg::frame_t frame_ring [RING_DEPTH];
  int               ring_head   = 0;
  int               ring_tail   = 0;
  int               ring_fill   = 0;
  logic [15:0]      drop_tally  = '0;

  // Bookkeeping shared by the stimulus, the driver and the checker.
  wiegand_event_t event_backlog [$];
  poll_result_t   outcome_fifo [$];
  wiegand_event_t next_event;
  poll_result_t   want;
  logic [31:0]    stamp_us         = '0;
  int             queued_reqs      = 0;
  int             accepted_reqs    = 0;
  int             results_total    = 0;
  int             frames_popped    = 0;
  int             drops_reported   = 0;
  int             mismatch_total   = 0;
  int             settings_written = 0;
  int             gap_left         = 0;
  int             hold_left        = 0;
  int             hold_requests    = 0;
  int             hold_served      = 0;
  int             quiet_cycles     = 0;
  bit             no_idle          = 1'b0;

  // Moves the open frame into the ring. A full ring loses its oldest frame,
  // and the loss is counted up to the 16-bit limit.
  function automatic void commit_open_frame();
    if (open_frame.count == 0) return;
    if (ring_fill >= RING_DEPTH) begin
      ring_head = (ring_head + 1) % RING_DEPTH;
      ring_fill--;
      if (drop_tally != wfcq_pkg::SAT16) drop_tally = drop_tally + 16'd1;
    end
    frame_ring[ring_tail] = open_frame;
    ring_tail = (ring_tail + 1) % RING_DEPTH;
    ring_fill++;
    open_frame = '0;
  endfunction

  // The gap is taken modulo 2^32, so a timestamp that wrapped still measures
  // the true distance from the last accepted pulse.
  function automatic void close_if_stale(logic [31:0] now);
    logic [31:0] gap;
    gap = now - open_frame.last;
    if (open_frame.count != 0 && gap >= timeout_cfg) commit_open_frame();
  endfunction

  function automatic void shift_pulse(logic level, logic [31:0] now);
    logic [31:0] gap;
    close_if_stale(now);
    gap = now - open_frame.last;
    // Spacing only matters inside a frame that is still open.
    if (open_frame.count != 0 && gap < {16'h0, spacing_cfg}) return;
    if (open_frame.count == 0) open_frame.first = now;
    if (level) begin
      if (open_frame.ones != wfcq_pkg::SAT16) open_frame.ones = open_frame.ones + 16'd1;
    end else begin
      if (open_frame.zeros != wfcq_pkg::SAT16) open_frame.zeros = open_frame.zeros + 16'd1;
    end
    // Past 63 bits the stored bits freeze and only the flag records the excess.
    if (open_frame.count < wfcq_pkg::BIT_LIMIT) begin
      open_frame.bits  = {open_frame.bits[61:0], level};
      open_frame.count = open_frame.count + 6'd1;
    end else begin
      open_frame.ovf = 1'b1;
    end
    open_frame.last = now;
  endfunction

  function automatic poll_result_t predict_event(logic [1:0] func, logic [31:0] now);
    poll_result_t res;
    res.valid   = 1'b0;
    res.frame   = '0;
    res.dropped = '0;
    if (func == wfcq_pkg::FUNC_ZERO || func == wfcq_pkg::FUNC_ONE) begin
      shift_pulse(func == wfcq_pkg::FUNC_ONE, now);
    end else if (func == wfcq_pkg::FUNC_POLL) begin
      close_if_stale(now);
      if (ring_fill > 0) begin
        res.valid   = 1'b1;
        res.frame   = frame_ring[ring_head];
        res.dropped = drop_tally;
        ring_head   = (ring_head + 1) % RING_DEPTH;
        ring_fill--;
        drop_tally  = '0;
      end
    end
    res.pending = (open_frame.count != 0) || (ring_fill > 0);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking.
  // ---------------------------------------------------------------------------
  function automatic void compare_field(string label, logic [63:0] got, logic [63:0] exp_val);
    if (got !== exp_val) begin
      mismatch_total++;
      if (mismatch_total <= MAX_SHOWN)
        $display("Result %0d, %s: expected %h, got %h", results_total, label, exp_val, got);
    end
  endfunction

  // The tdata layout follows the port comment of the block, lowest field first.
  task automatic check_result(poll_result_t exp_res);
    compare_field("frame_valid", m_tuser_o, exp_res.valid);
    compare_field("frame_bits", m_tdata_o[62:0], exp_res.frame.bits);
    compare_field("bit_total", m_tdata_o[68:63], exp_res.frame.count);
    compare_field("first_pulse_time", m_tdata_o[100:69], exp_res.frame.first);
    compare_field("last_pulse_time", m_tdata_o[132:101], exp_res.frame.last);
    compare_field("overflowed", m_tdata_o[133], exp_res.frame.ovf);
    compare_field("zero_pulses", m_tdata_o[149:134], exp_res.frame.zeros);
    compare_field("one_pulses", m_tdata_o[165:150], exp_res.frame.ones);
    compare_field("dropped_total", m_tdata_o[181:166], exp_res.dropped);
    compare_field("pending", m_tdata_o[182], exp_res.pending);
    compare_field("tdata padding", m_tdata_o[183], 1'b0);
    results_total++;
    if (exp_res.valid) frames_popped++;
    if (exp_res.dropped != 0) drops_reported++;
  endtask

  // The monitor watches both channels. Prediction happens at the edge that
  // accepts a request, so the expectation is queued before its result can
  // possibly show up on the output.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_o) begin
        outcome_fifo.push_back(predict_event(s_tuser_i, s_tdata_i));
        accepted_reqs++;
      end
      if (m_tvalid_o && m_tready_i) begin
        if (outcome_fifo.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= MAX_SHOWN)
            $display("Result with no outstanding request: tuser %b, tdata %h",
                     m_tuser_o, m_tdata_o);
        end else begin
          want = outcome_fifo.pop_front();
          check_result(want);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver and receiver.
  // ---------------------------------------------------------------------------
  // Idle stretches are mostly short, with an occasional long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A request stays on the bus until it is taken; the gap counter only runs
  // while the bus is free.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid_i <= 1'b0;
    end else if (!s_tvalid_i || s_tready_o) begin
      if (gap_left > 0 || event_backlog.size() == 0) begin
        s_tvalid_i <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        next_event = event_backlog.pop_front();
        s_tvalid_i <= 1'b1;
        s_tuser_i  <= next_event.func;
        s_tdata_i  <= next_event.now;
        gap_left   <= (no_idle || $urandom_range(0, 99) < 60) ? 0 : idle_len();
      end
    end
  end

  // The receiver stalls at random. A hold request from the stimulus makes it
  // refuse results for a long stretch so that the block backs up into its input.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready_i <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= LONG_HOLD_CYCLES - 1;
      m_tready_i  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      m_tready_i <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 99) < 20) begin
      hold_left  <= idle_len() - 1;
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= 1'b1;
    end
  end

  // Ends the run if neither channel moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                 quiet_cycles, outcome_fifo.size());
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  task automatic push_event(logic [1:0] func, logic [31:0] now);
    wiegand_event_t ev;
    ev.func = func;
    ev.now  = now;
    event_backlog.push_back(ev);
    queued_reqs++;
  endtask

  // A gap that is certain to close the open frame, clipped at the largest
  // distance that the 32-bit timestamp can express.
  function automatic logic [31:0] frame_gap();
    logic [63:0] g;
    g = {32'h0, timeout_cfg} + $urandom_range(0, 3000);
    return (g > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : g[31:0];
  endfunction

  // Sends one card read: a run of pulses at legal spacing, with the odd glitch
  // that comes too soon, then usually a poll once the frame has timed out.
  // Skipping the poll lets frames pile up in the ring until they are dropped.
  task automatic send_frame();
    int r;
    int len;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      case ($urandom_range(0, 2))
        0:       len = 26;
        1:       len = 34;
        default: len = 37;
      endcase
    end else if (r < 85) begin
      len = $urandom_range(1, 40);
    end else begin
      len = $urandom_range(60, 70);
    end
    for (int i = 0; i < len; i++) begin
      if (i > 0 && spacing_cfg != 0 && $urandom_range(0, 19) == 0)
        push_event($urandom_range(0, 1) ? wfcq_pkg::FUNC_ONE : wfcq_pkg::FUNC_ZERO,
                   stamp_us + $urandom_range(0, spacing_cfg - 1));
      stamp_us += spacing_cfg + $urandom_range(1, 1500);
      push_event($urandom_range(0, 1) ? wfcq_pkg::FUNC_ONE : wfcq_pkg::FUNC_ZERO, stamp_us);
    end
    r = $urandom_range(0, 99);
    if (r >= 50 && r < 65) push_event(wfcq_pkg::FUNC_POLL, stamp_us + $urandom_range(0, 2000));
    stamp_us += frame_gap();
    if (r < 65) begin
      push_event(wfcq_pkg::FUNC_POLL, stamp_us);
      if ($urandom_range(0, 2) == 0)
        push_event(wfcq_pkg::FUNC_POLL, stamp_us + $urandom_range(0, 500));
    end
  endtask

  // Mostly well-formed frames, the rest stray events and bursts of polls.
  task automatic gen_traffic(int n);
    int start;
    start = queued_reqs;
    while (queued_reqs - start < n) begin
      if ($urandom_range(0, 99) < 75) begin
        send_frame();
      end else begin
        case ($urandom_range(0, 3))
          0: push_event(2'($urandom_range(0, 3)), $urandom());
          1: push_event(FUNC_UNUSED, stamp_us + $urandom_range(0, 100));
          2: push_event(wfcq_pkg::FUNC_POLL, stamp_us + $urandom_range(0, 5000));
          default: begin
            repeat ($urandom_range(3, 10)) begin
              stamp_us += frame_gap();
              push_event(wfcq_pkg::FUNC_POLL, stamp_us);
            end
          end
        endcase
      end
    end
  endtask

  // Waits until every request has been taken and every result checked.
  task automatic wait_until_drained();
    while (accepted_reqs != queued_reqs || outcome_fifo.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write: a setup phase, then an access phase that completes at
  // once since pready is always high.
  task automatic write_register(logic idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == wfcq_pkg::REG_TIMEOUT) timeout_cfg = value;
    else spacing_cfg = value[15:0];
    settings_written++;
  endtask

  // Drains the block, sets both registers and queues a batch of traffic.
  task automatic run_phase(logic [31:0] timeout, logic [15:0] spacing, int n,
                           bit hold_output, bit steady);
    wait_until_drained();
    write_register(wfcq_pkg::REG_TIMEOUT, timeout);
    write_register(wfcq_pkg::REG_MIN_SPACING, {16'h0, spacing});
    no_idle = steady;
    gen_traffic(n);
    if (hold_output) hold_requests++;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests under the reset settings: an empty poll, the unused
    // code, a short frame with a pulse that comes too soon, polls just before
    // and at the timeout, a frame that spans the timestamp wrap, and a pulse
    // that arrives after the timeout and so opens a new frame.
    push_event(wfcq_pkg::FUNC_POLL, 32'h0000_0000);
    push_event(FUNC_UNUSED, 32'hFFFF_FFFF);
    push_event(wfcq_pkg::FUNC_ZERO, 32'd1000);
    push_event(wfcq_pkg::FUNC_ONE, 32'd2000);
    push_event(wfcq_pkg::FUNC_ONE, 32'd2100);
    push_event(wfcq_pkg::FUNC_ZERO, 32'd3000);
    push_event(FUNC_UNUSED, 32'd3050);
    push_event(wfcq_pkg::FUNC_POLL, 32'd32999);
    push_event(wfcq_pkg::FUNC_POLL, 32'd33000);
    push_event(wfcq_pkg::FUNC_ONE, 32'hFFFF_FF00);
    push_event(wfcq_pkg::FUNC_ZERO, 32'h0000_0100);
    push_event(wfcq_pkg::FUNC_ONE, 32'h0000_0100 + 32'd30000);
    push_event(wfcq_pkg::FUNC_POLL, 32'h0000_0100 + 32'd30001);
    push_event(wfcq_pkg::FUNC_POLL, 32'h0000_0100 + 32'd60000);
    push_event(wfcq_pkg::FUNC_POLL, 32'h0000_0100 + 32'd60001);
    stamp_us = 32'h0001_0000;

    // Random phases over a spread of settings, extremes included. A timeout of
    // zero closes the open frame on every pulse or poll.
    run_phase(32'd25000, 16'd300, 500, 1'b1, 1'b0);
    run_phase(32'd1, 16'd0, 250, 1'b0, 1'b0);
    run_phase(32'hFFFF_FFFF, 16'hFFFF, 250, 1'b1, 1'b0);
    run_phase(32'd0, 16'd0, 200, 1'b0, 1'b0);

    // With a zero timeout every pulse closes the previous frame, so a run
    // without polls overruns the ring and the oldest frames are dropped.
    wait_until_drained();
    no_idle = 1'b1;
    repeat (RING_DEPTH + 6) begin
      stamp_us += 1;
      push_event(wfcq_pkg::FUNC_ONE, stamp_us);
    end
    repeat (RING_DEPTH + 2) push_event(wfcq_pkg::FUNC_POLL, stamp_us);

    // With the largest timeout one frame collects more pulses than the bit
    // store holds. Only a poll one tick behind the last pulse is far enough
    // away to close it.
    run_phase(32'hFFFF_FFFF, 16'd0, 0, 1'b0, 1'b1);
    repeat (BIT_OVERRUN) begin
      stamp_us += 1;
      push_event($urandom_range(0, 1) ? wfcq_pkg::FUNC_ONE : wfcq_pkg::FUNC_ZERO, stamp_us);
    end
    push_event(wfcq_pkg::FUNC_POLL, stamp_us - 1);
    push_event(wfcq_pkg::FUNC_POLL, stamp_us - 1);

    run_phase(wfcq_pkg::TIMEOUT_RESET, wfcq_pkg::MIN_SPACING_RESET, 300, 1'b0, 1'b1);
    run_phase(32'd40000, 16'd150, 400, 1'b1, 1'b0);

    wait_until_drained();
    repeat (10) @(posedge clk_i);
    $display("Checked %0d results from %0d requests; %0d carried a frame, %0d reported drops.",
             results_total, accepted_reqs, frames_popped, drops_reported);
    $display("Register writes: %0d; mismatches: %0d.", settings_written, mismatch_total);
    if (mismatch_total == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== wiegand_frame_capture_queue_unit.f =====
sv/wfcq_pkg.sv
sv/wiegand_frame_capture_queue_unit.sv
tb/wiegand_frame_capture_queue_unit_tb.sv
